// File: hdl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and constants for the positional ordered list unit.
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int DATA_W     = 32;
	localparam int POS_W      = 8;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 3;
	// search tree fan-in is 1 << TREE_FAN_LOG
	localparam int TREE_FAN_LOG = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_LOCATE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 3'd0,
		STATUS_FULL      = 3'd1,
		STATUS_EMPTY     = 3'd2,
		STATUS_BAD_POS   = 3'd3,
		STATUS_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	// strobes broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic get;
		logic loc;
	} pol_ctl_t;

endpackage

// File: hdl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// One list slot: holds an entry, shifts with its neighbors on insert and
// delete, and registers its own hit flag for get and locate.
// ----------------------------------------------------------------------------
module pol_cell #(
	parameter int CMPW = 9,
	parameter int IDX  = 0
) (
	input  logic                        clk,
	input  pol_pkg::pol_ctl_t           ctl,
	input  logic [CMPW-1:0]             pos,
	input  logic [CMPW-1:0]             count,
	input  logic [pol_pkg::DATA_W-1:0]  value,
	input  logic [pol_pkg::DATA_W-1:0]  prev_entry,
	input  logic [pol_pkg::DATA_W-1:0]  next_entry,
	output logic [pol_pkg::DATA_W-1:0]  entry,
	output logic                        hit
);

	localparam logic [CMPW-1:0] POS_HERE = CMPW'(IDX + 1);
	localparam logic [CMPW-1:0] IDX_HERE = CMPW'(IDX);

	logic [pol_pkg::DATA_W-1:0] entry_q;
	logic                       hit_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (POS_HERE == pos) begin
				entry_q <= value;
			end else if (IDX_HERE >= pos) begin
				entry_q <= prev_entry;
			end
		end else if (ctl.del) begin
			if (POS_HERE >= pos) begin
				entry_q <= next_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.get) begin
			hit_q <= (POS_HERE == pos) && (IDX_HERE < count);
		end else if (ctl.loc) begin
			hit_q <= (entry_q == value) && (IDX_HERE < count);
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

// File: hdl/pol_tree.sv
// ----------------------------------------------------------------------------
// pol_tree
// Registered priority tree over the cell hit flags: returns the lowest
// index that hits and the entry held there.
// ----------------------------------------------------------------------------
module pol_tree #(
	parameter int N = 128
) (
	input  logic                        clk,
	input  logic                        leaf_hit  [N],
	input  logic [pol_pkg::DATA_W-1:0]  leaf_data [N],
	output logic                        root_hit,
	output logic [$clog2(N)-1:0]        root_idx,
	output logic [pol_pkg::DATA_W-1:0]  root_data
);

	localparam int IW     = $clog2(N);
	localparam int FL     = pol_pkg::TREE_FAN_LOG;
	localparam int FAN    = 1 << FL;
	localparam int LEVELS = (IW + FL - 1) / FL;
	localparam int PAD    = 1 << (FL * LEVELS);

	// row l-1 holds the registers of tree level l
	logic                       hit_l  [LEVELS][PAD];
	logic [IW-1:0]              idx_l  [LEVELS][PAD];
	logic [pol_pkg::DATA_W-1:0] data_l [LEVELS][PAD];

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		for (genvar k = 0; k < PAD; k++) begin : g_node
			if (k < (PAD >> (FL * l))) begin : g_used
				logic                       ch_hit  [FAN];
				logic [IW-1:0]              ch_idx  [FAN];
				logic [pol_pkg::DATA_W-1:0] ch_data [FAN];
				logic                       h_c;
				logic [IW-1:0]              i_c;
				logic [pol_pkg::DATA_W-1:0] d_c;

				for (genvar c = 0; c < FAN; c++) begin : g_child
					if (l > 1) begin : g_inner
						assign ch_hit[c]  = hit_l[l-2][k*FAN+c];
						assign ch_idx[c]  = idx_l[l-2][k*FAN+c];
						assign ch_data[c] = data_l[l-2][k*FAN+c];
					end else if (k * FAN + c < N) begin : g_real
						assign ch_hit[c]  = leaf_hit[k*FAN+c];
						assign ch_idx[c]  = IW'(k * FAN + c);
						assign ch_data[c] = leaf_data[k*FAN+c];
					end else begin : g_pad
						assign ch_hit[c]  = 1'b0;
						assign ch_idx[c]  = '0;
						assign ch_data[c] = '0;
					end
				end

				// lowest child that hits wins
				always_comb begin
					h_c = 1'b0;
					i_c = '0;
					d_c = '0;
					for (int c = FAN - 1; c >= 0; c--) begin
						if (ch_hit[c]) begin
							h_c = 1'b1;
							i_c = ch_idx[c];
							d_c = ch_data[c];
						end
					end
				end

				always_ff @(posedge clk) begin
					hit_l[l-1][k]  <= h_c;
					idx_l[l-1][k]  <= i_c;
					data_l[l-1][k] <= d_c;
				end
			end else begin : g_unused
				always_ff @(posedge clk) begin
					hit_l[l-1][k]  <= 1'b0;
					idx_l[l-1][k]  <= '0;
					data_l[l-1][k] <= '0;
				end
			end
		end
	end

	assign root_hit  = hit_l[LEVELS-1][0];
	assign root_idx  = idx_l[LEVELS-1][0];
	assign root_data = data_l[LEVELS-1][0];

endmodule

// File: hdl/positional_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_unit
// Bounded ordered list of signed 32-bit entries with insert, delete, get and
// locate by 1-based position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word: tuser = cmd, tdata = position, value.
//   m_axis returns one result word per command: tuser = status, tdata =
//   read_value, found_position, list_length.
//   Insert and delete shift the cells from the given position onward at once
//   in the cycle the word is taken; their result shows on m_axis the next
//   cycle, and a new command can be taken every cycle while the result
//   register drains. Get and locate register a hit flag in each cell, then
//   walk a fan-in-4 registered priority tree of ceil(log4(MAX_ENTRIES))
//   levels; the tree root is then captured into the result register, and
//   no new word is taken until that capture, so searches do not overlap.
//   Reset empties the list; entry contents are left as they are.
//   If m_axis stalls, the result is held and s_axis_tready drops until the
//   result register can be reloaded; a finished search waits in the tree.
// ----------------------------------------------------------------------------
module positional_ordered_list_unit #(
	parameter int MAX_ENTRIES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // position[7:0], value[39:8]
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // read_value[31:0], found_position[39:32],
	                                   // list_length[47:40]
	output logic [2:0]  m_axis_tuser   // status[2:0]
);

	localparam int N      = MAX_ENTRIES;
	localparam int IW     = $clog2(N);
	localparam int CW     = $clog2(N + 1);
	localparam int CMPW   = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;
	localparam int FL     = pol_pkg::TREE_FAN_LOG;
	localparam int LEVELS = (IW + FL - 1) / FL;
	localparam int WCW    = $clog2(LEVELS + 2);
	localparam int DW     = pol_pkg::DATA_W;
	localparam int PW     = pol_pkg::POS_W;

	pol_pkg::state_t  state_q, state_nxt;
	logic [CW-1:0]    count_q;
	logic [WCW-1:0]   wait_q;
	logic             op_get_q;

	logic             out_valid_q;
	pol_pkg::status_t status_q;
	logic [DW-1:0]    read_value_q;
	logic [PW-1:0]    found_q;
	logic [PW-1:0]    length_q;

	pol_pkg::cmd_t     cmd;
	pol_pkg::pol_ctl_t ctl;
	logic              accept;
	logic              out_free;
	logic              capture;
	logic [CMPW-1:0]   pos_ext;
	logic [CMPW-1:0]   count_ext;
	logic [DW-1:0]     value;
	logic              ins_ok;
	logic              del_ok;
	pol_pkg::status_t  imm_status;

	logic              cell_hit   [N];
	logic [DW-1:0]     cell_entry [N];
	logic              root_hit;
	logic [IW-1:0]     root_idx;
	logic [DW-1:0]     root_data;

	assign cmd       = pol_pkg::cmd_t'(s_axis_tuser);
	assign pos_ext   = CMPW'(s_axis_tdata[PW-1:0]);
	assign value     = s_axis_tdata[PW+DW-1:PW];
	assign count_ext = CMPW'(count_q);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign accept    = s_axis_tvalid && s_axis_tready;

	assign ins_ok = (count_ext != CMPW'(N)) && (pos_ext != '0)
		&& (pos_ext <= count_ext + CMPW'(1));
	assign del_ok = (count_ext != '0) && (pos_ext != '0) && (pos_ext <= count_ext);

	always_comb begin
		case (cmd)
			pol_pkg::CMD_INSERT: begin
				if (count_ext == CMPW'(N)) begin
					imm_status = pol_pkg::STATUS_FULL;
				end else if (!ins_ok) begin
					imm_status = pol_pkg::STATUS_BAD_POS;
				end else begin
					imm_status = pol_pkg::STATUS_OK;
				end
			end
			pol_pkg::CMD_DELETE: begin
				if (count_ext == '0) begin
					imm_status = pol_pkg::STATUS_EMPTY;
				end else if (!del_ok) begin
					imm_status = pol_pkg::STATUS_BAD_POS;
				end else begin
					imm_status = pol_pkg::STATUS_OK;
				end
			end
			default: begin
				imm_status = pol_pkg::STATUS_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pol_pkg::S_IDLE: begin
				if (accept && (cmd == pol_pkg::CMD_GET || cmd == pol_pkg::CMD_LOCATE)) begin
					state_nxt = pol_pkg::S_SEARCH;
				end
			end
			pol_pkg::S_SEARCH: begin
				if (capture) begin
					state_nxt = pol_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = pol_pkg::S_IDLE;
			end
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_axis_tready = 1'b0;
		capture       = 1'b0;
		case (state_q)
			pol_pkg::S_IDLE: begin
				s_axis_tready = out_free;
			end
			pol_pkg::S_SEARCH: begin
				// wait for the hit flags and then every tree level to be registered
				capture = (wait_q == WCW'(LEVELS + 1)) && out_free;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
		ctl.ins = accept && (cmd == pol_pkg::CMD_INSERT) && ins_ok;
		ctl.del = accept && (cmd == pol_pkg::CMD_DELETE) && del_ok;
		ctl.get = accept && (cmd == pol_pkg::CMD_GET);
		ctl.loc = accept && (cmd == pol_pkg::CMD_LOCATE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pol_pkg::S_IDLE;
			count_q     <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.del) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				wait_q <= '0;
			end else if (state_q == pol_pkg::S_SEARCH && wait_q != WCW'(LEVELS + 1)) begin
				wait_q <= wait_q + WCW'(1);
			end
			if ((accept && !ctl.get && !ctl.loc) || capture) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_get_q <= (cmd == pol_pkg::CMD_GET);
		end
		if (accept && !ctl.get && !ctl.loc) begin
			status_q     <= imm_status;
			read_value_q <= '0;
			found_q      <= '0;
			if (ctl.ins) begin
				length_q <= PW'(count_q + CW'(1));
			end else if (ctl.del) begin
				length_q <= PW'(count_q - CW'(1));
			end else begin
				length_q <= PW'(count_q);
			end
		end else if (capture) begin
			length_q <= PW'(count_q);
			if (op_get_q) begin
				status_q     <= root_hit ? pol_pkg::STATUS_OK : pol_pkg::STATUS_BAD_POS;
				read_value_q <= root_hit ? root_data : '0;
				found_q      <= '0;
			end else begin
				status_q     <= root_hit ? pol_pkg::STATUS_OK : pol_pkg::STATUS_NOT_FOUND;
				read_value_q <= '0;
				found_q      <= root_hit ? (PW'(root_idx) + PW'(1)) : '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [DW-1:0] prev_w;
		logic [DW-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = cell_entry[i];
		end else begin : g_mid_prev
			assign prev_w = cell_entry[i-1];
		end
		if (i == N - 1) begin : g_last
			assign next_w = cell_entry[i];
		end else begin : g_mid_next
			assign next_w = cell_entry[i+1];
		end

		pol_cell #(
			.CMPW (CMPW),
			.IDX  (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.pos        (pos_ext),
			.count      (count_ext),
			.value      (value),
			.prev_entry (prev_w),
			.next_entry (next_w),
			.entry      (cell_entry[i]),
			.hit        (cell_hit[i])
		);
	end

	pol_tree #(
		.N (N)
	) u_tree (
		.clk       (clk),
		.leaf_hit  (cell_hit),
		.leaf_data (cell_entry),
		.root_hit  (root_hit),
		.root_idx  (root_idx),
		.root_data (root_data)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {length_q, found_q, read_value_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("list length beyond capacity");

	a_no_take_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pol_pkg::S_SEARCH |-> !s_axis_tready)
		else $error("word taken during search");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del |=> count_q == $past(count_q) - CW'(1))
		else $error("delete did not shrink the list");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional ordered list unit. Commands go in
// on s_axis; a behavioral list in the bench predicts each result word,
// and the checker compares every m_axis word field by field. Directed
// corner cases come first, then a fill to capacity and a drain, a pause
// until all results are back, and random traffic under four idle and
// stall patterns.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ENTRIES = 128;
	localparam int STALL_LIMIT = 1000;
	localparam int END_WAIT    = 20;

	typedef struct {
		pol_pkg::status_t status;
		logic [31:0]      read_value;
		logic [7:0]       found_position;
		logic [7:0]       list_length;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // position[7:0], value[39:8]
	logic [1:0]  s_axis_tuser = '0;  // cmd[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // read_value[31:0], found_position[39:32],
	                                 // list_length[47:40]
	logic [2:0]  m_axis_tuser;       // status[2:0]

	// bench copy of the list contents, position 1 first
	logic [31:0]  list_entries[$];
	list_result_t pending_results[$];

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int error_count = 0;
	int words_sent = 0;
	int results_checked = 0;
	int status_seen[5];
	int peak_length = 0;
	int idle_cycles = 0;

	positional_ordered_list_unit #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic list_result_t apply_list_cmd(pol_pkg::cmd_t cmd, logic [7:0] pos,
			logic [31:0] val);
		list_result_t r;
		int len;
		int p;
		len = list_entries.size();
		p = int'(pos);
		r.status = pol_pkg::STATUS_OK;
		r.read_value = '0;
		r.found_position = '0;
		case (cmd)
			pol_pkg::CMD_INSERT: begin
				// fullness wins over a bad position
				if (len >= MAX_ENTRIES)
					r.status = pol_pkg::STATUS_FULL;
				else if (p == 0 || p > len + 1)
					r.status = pol_pkg::STATUS_BAD_POS;
				else
					list_entries.insert(p - 1, val);
			end
			pol_pkg::CMD_DELETE: begin
				if (len == 0)
					r.status = pol_pkg::STATUS_EMPTY;
				else if (p == 0 || p > len)
					r.status = pol_pkg::STATUS_BAD_POS;
				else
					list_entries.delete(p - 1);
			end
			pol_pkg::CMD_GET: begin
				if (p == 0 || p > len)
					r.status = pol_pkg::STATUS_BAD_POS;
				else
					r.read_value = list_entries[p - 1];
			end
			default: begin
				r.status = pol_pkg::STATUS_NOT_FOUND;
				for (int j = 0; j < len; j++) begin
					if (list_entries[j] == val) begin
						r.status = pol_pkg::STATUS_OK;
						r.found_position = 8'(j + 1);
						break;
					end
				end
			end
		endcase
		r.list_length = 8'(list_entries.size());
		return r;
	endfunction

	task automatic send_word(input pol_pkg::cmd_t cmd, input logic [7:0] pos,
			input logic [31:0] val);
		list_result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {val, pos};
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = apply_list_cmd(cmd, pos, val);
		pending_results.push_back(r);
		status_seen[r.status]++;
		if (list_entries.size() > peak_length)
			peak_length = list_entries.size();
		words_sent++;
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			// small pool so duplicates and locate hits are common
			4, 5: return 32'($urandom_range(7));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_word(input int ins_pct);
		pol_pkg::cmd_t cmd;
		logic [7:0]    pos;
		logic [31:0]   val;
		int            len;
		int            r;
		int            span;
		len = list_entries.size();
		r = $urandom_range(99);
		span = 100 - ins_pct;
		if (r < ins_pct)
			cmd = pol_pkg::CMD_INSERT;
		else if (r - ins_pct < span * 4 / 10)
			cmd = pol_pkg::CMD_DELETE;
		else if (r - ins_pct < span * 7 / 10)
			cmd = pol_pkg::CMD_GET;
		else
			cmd = pol_pkg::CMD_LOCATE;
		if ($urandom_range(99) < 12)
			pos = 8'($urandom_range(255));
		else if (cmd == pol_pkg::CMD_INSERT)
			pos = 8'($urandom_range(len + 1, 1));
		else
			pos = 8'($urandom_range(len > 0 ? len : 1, 1));
		if (cmd == pol_pkg::CMD_LOCATE && len > 0 && $urandom_range(1))
			val = list_entries[$urandom_range(len - 1)];
		else
			val = pick_value();
		send_word(cmd, pos, val);
	endtask

	task automatic test_edge_cases();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_word(pol_pkg::CMD_GET, 8'd1, 32'd0);              // get on empty list
		send_word(pol_pkg::CMD_DELETE, 8'd0, 32'd0);           // empty beats bad position
		send_word(pol_pkg::CMD_LOCATE, 8'd0, 32'd0);           // locate on empty list
		send_word(pol_pkg::CMD_INSERT, 8'd0, 32'd5);
		send_word(pol_pkg::CMD_INSERT, 8'd2, 32'd5);
		send_word(pol_pkg::CMD_INSERT, 8'd1, 32'h8000_0000);
		send_word(pol_pkg::CMD_INSERT, 8'd2, 32'h7fff_ffff);
		send_word(pol_pkg::CMD_INSERT, 8'd1, 32'hffff_ffff);   // head insert
		send_word(pol_pkg::CMD_INSERT, 8'd2, 32'h0000_0000);   // middle insert
		send_word(pol_pkg::CMD_INSERT, 8'd5, 32'h7fff_ffff);   // tail insert, duplicate
		send_word(pol_pkg::CMD_GET, 8'd1, 32'd0);
		send_word(pol_pkg::CMD_GET, 8'd5, 32'd0);
		send_word(pol_pkg::CMD_GET, 8'd6, 32'd0);
		send_word(pol_pkg::CMD_GET, 8'd255, 32'hffff_ffff);
		send_word(pol_pkg::CMD_LOCATE, 8'd255, 32'h7fff_ffff); // first of two matches
		send_word(pol_pkg::CMD_LOCATE, 8'd0, 32'h1234_5678);
		send_word(pol_pkg::CMD_INSERT, 8'd7, 32'd1);
		send_word(pol_pkg::CMD_INSERT, 8'd255, 32'd1);
		send_word(pol_pkg::CMD_DELETE, 8'd0, 32'd0);
		send_word(pol_pkg::CMD_DELETE, 8'd6, 32'd0);
		send_word(pol_pkg::CMD_DELETE, 8'd3, 32'd0);
		send_word(pol_pkg::CMD_DELETE, 8'd4, 32'd0);
		send_word(pol_pkg::CMD_DELETE, 8'd1, 32'd0);
		send_word(pol_pkg::CMD_LOCATE, 8'd0, 32'h7fff_ffff);
		wait_results_drained();
	endtask

	task automatic test_fill_and_drain();
		src_idle_pct = 19;
		snk_stall_pct = 19;
		while (list_entries.size() < MAX_ENTRIES)
			send_word(pol_pkg::CMD_INSERT,
				8'($urandom_range(list_entries.size() + 1, 1)), pick_value());
		// full is reported ahead of any position check
		send_word(pol_pkg::CMD_INSERT, 8'd0, 32'd1);
		send_word(pol_pkg::CMD_INSERT, 8'd1, 32'd1);
		send_word(pol_pkg::CMD_INSERT, 8'd129, 32'd1);
		send_word(pol_pkg::CMD_INSERT, 8'd255, 32'd1);
		send_word(pol_pkg::CMD_GET, 8'd128, 32'd0);
		send_word(pol_pkg::CMD_GET, 8'd129, 32'd0);
		send_word(pol_pkg::CMD_LOCATE, 8'd0, list_entries[MAX_ENTRIES - 1]);
		send_word(pol_pkg::CMD_DELETE, 8'd129, 32'd0);
		send_word(pol_pkg::CMD_DELETE, 8'd128, 32'd0);
		while (list_entries.size() > 0)
			send_word(pol_pkg::CMD_DELETE,
				8'($urandom_range(list_entries.size(), 1)), 32'd0);
		send_word(pol_pkg::CMD_DELETE, 8'd255, 32'd0);
		send_word(pol_pkg::CMD_INSERT, 8'd1, 32'h8000_0000);
		wait_results_drained();
	endtask

	task automatic test_pause_until_drained();
		src_idle_pct = 0;
		snk_stall_pct = 47;
		repeat (12)
			send_random_word(55);
		wait_results_drained();
		repeat (12)
			send_random_word(55);
		wait_results_drained();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		// alternate growth and shrink so length sweeps the whole range
		for (int i = 0; i < 320; i++)
			send_random_word(((i / 100) % 2 == 0) ? 62 : 26);
		wait_results_drained();
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		test_edge_cases();
		test_fill_and_drain();
		test_pause_until_drained();
		test_random_traffic(0, 0);
		test_random_traffic(47, 0);
		test_random_traffic(0, 47);
		test_random_traffic(19, 19);
		wait_results_drained();
		repeat (END_WAIT)
			@(posedge clk);
		$display("covered %0d commands, %0d results checked, peak length %0d",
			words_sent, results_checked, peak_length);
		$display("status counts: ok %0d full %0d empty %0d bad position %0d not found %0d",
			status_seen[pol_pkg::STATUS_OK], status_seen[pol_pkg::STATUS_FULL],
			status_seen[pol_pkg::STATUS_EMPTY], status_seen[pol_pkg::STATUS_BAD_POS],
			status_seen[pol_pkg::STATUS_NOT_FOUND]);
		if (error_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

	function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (actv !== expv) begin
			$display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, expv,
				actv);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got 0x%012h status %0d",
					$time, m_axis_tdata, m_axis_tuser);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", 32'(exp_r.status), 32'(m_axis_tuser));
				check_field("read_value", exp_r.read_value, m_axis_tdata[31:0]);
				check_field("found_position", 32'(exp_r.found_position),
					32'(m_axis_tdata[39:32]));
				check_field("list_length", 32'(exp_r.list_length), 32'(m_axis_tdata[47:40]));
				results_checked++;
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
